@@ rtl/kss_pkg.sv @@
`timescale 1ns / 1ps
// Package for the shared-array stack unit: command, status and payload types.
// No dependencies; the unit and the testbench import it.
package kss_pkg;

	localparam int ValueWidth   = 32;
	localparam int StackIdWidth = 2;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		command_t                        command;
		logic [StackIdWidth-1:0]         stack_id;
		logic signed [ValueWidth-1:0]    value;
	} req_t;

	typedef struct packed {
		logic signed [ValueWidth-1:0]    data_out;
		status_t                         status;
	} rsp_t;

endpackage

@@ rtl/kss_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of a given type per transaction.
// Depends on nothing; payload types come from kss_pkg at instantiation.
interface kss_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/kss_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/k_stacks_shared_array_unit.sv @@
`timescale 1ns / 1ps
// Channel | dir | payload                              | accepted when
// req     | in  | command, stack_id, value             | req.valid && req.ready
// rsp     | out | data_out, status                     | rsp.valid && rsp.ready
//
// A transaction reads the data and link RAMs on accept, at the slot picked by the
// free head or the stack top; the write-back follows while busy_q is set.
// One command is in flight at a time; a new one is taken once the result register
// is free or being drained. No clearing pass: a slot at or above the allocation
// mark links to slot plus one. Reset (arst_n low) empties all stacks at once.
// Depends on kss_pkg, kss_if and kss_ram.
module k_stacks_shared_array_unit #(
	parameter int NUM_STACKS = 4,
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	kss_if.sink   req,
	kss_if.source rsp
);
	import kss_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int PW    = $clog2(CAPACITY + 1);
	localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int SIDW  = SW + StackIdWidth;
	localparam int WIDEW = (DATA_WIDTH > ValueWidth) ? DATA_WIDTH : ValueWidth;
	localparam logic [PW-1:0] EMPTY_PTR = PW'(CAPACITY);

	logic [PW-1:0]         tops_q [NUM_STACKS];
	logic [PW-1:0]         free_head_q;
	logic [PW-1:0]         alloc_mark_q;   // slots below this were ever allocated
	logic                  busy_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	command_t              command_s1;
	logic [SW-1:0]         idx_s1;
	logic [DATA_WIDTH-1:0] value_s1;
	logic [AW-1:0]         slot_s1;
	logic                  ok_s1;
	logic                  fresh_s1;

	logic                  accept;
	logic [SIDW-1:0]       sid_wide;
	logic [SW-1:0]         idx_c;
	logic                  sid_ok;
	logic [PW-1:0]         slot_c;
	logic                  ok_c;

	logic [DATA_WIDTH-1:0] data_rdata;
	logic [PW-1:0]         link_rdata;
	logic [PW-1:0]         link_next;
	logic                  data_we;
	logic                  link_we;
	logic [PW-1:0]         link_wdata;
	logic [WIDEW-1:0]      pop_wide;

	assign req.ready = !busy_q && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign sid_wide = SIDW'(req.payload.stack_id);
	assign idx_c    = sid_wide[SW-1:0];
	assign sid_ok   = sid_wide < SIDW'(NUM_STACKS);

	always_comb begin
		unique case (req.payload.command)
			CMD_PUSH: slot_c = free_head_q;
			CMD_POP:  slot_c = tops_q[idx_c];
			default:  slot_c = free_head_q;
		endcase
	end
	assign ok_c = sid_ok && (slot_c < EMPTY_PTR);

	// Never-allocated slots take the initial link, slot plus one, not the RAM contents.
	assign link_next = fresh_s1 ? (PW'(slot_s1) + PW'(1)) : link_rdata;

	assign data_we    = busy_q && ok_s1 && (command_s1 == CMD_PUSH);
	assign link_we    = busy_q && ok_s1;
	assign link_wdata = (command_s1 == CMD_PUSH) ? tops_q[idx_s1] : free_head_q;
	assign pop_wide   = WIDEW'(data_rdata);

	kss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (slot_s1),
		.wdata (value_s1),
		.re    (accept),
		.raddr (slot_c[AW-1:0]),
		.rdata (data_rdata)
	);

	kss_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (slot_s1),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (slot_c[AW-1:0]),
		.rdata (link_rdata)
	);

	// Stage 1 capture: payload, slot and flags, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= req.payload.command;
			idx_s1     <= idx_c;
			value_s1   <= DATA_WIDTH'($unsigned(req.payload.value));
			slot_s1    <= slot_c[AW-1:0];
			ok_s1      <= ok_c;
			fresh_s1   <= slot_c >= alloc_mark_q;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (ok_s1 && (command_s1 == CMD_POP)) begin
				rsp_q.data_out <= pop_wide[ValueWidth-1:0];
				rsp_q.status   <= ST_OK;
			end else if (ok_s1) begin
				rsp_q.data_out <= '0;
				rsp_q.status   <= ST_OK;
			end else begin
				rsp_q.data_out <= '0;
				rsp_q.status   <= (command_s1 == CMD_PUSH) ? ST_FULL : ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				tops_q[i] <= EMPTY_PTR;
			end
			free_head_q  <= '0;
			alloc_mark_q <= '0;
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			busy_q <= accept;
			if (busy_q) begin
				rsp_valid_q <= 1'b1;
				if (ok_s1 && (command_s1 == CMD_PUSH)) begin
					free_head_q    <= link_next;
					tops_q[idx_s1] <= PW'(slot_s1);
					if (fresh_s1) begin
						alloc_mark_q <= alloc_mark_q + PW'(1);
					end
				end else if (ok_s1) begin
					tops_q[idx_s1] <= link_next;
					free_head_q    <= PW'(slot_s1);
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q <= EMPTY_PTR) && (alloc_mark_q <= EMPTY_PTR))
		else $error("free head or allocation mark beyond capacity");

	a_work_completes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> rsp_valid_q)
		else $error("command in flight produced no result");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !accept)
		else $error("command accepted while another is in flight");

	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(busy_q) && ($past(command_s1) == CMD_PUSH) |-> (rsp_q.data_out == '0))
		else $error("push result carries nonzero data");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for k_stacks_shared_array_unit. It runs a directed push/pop table and then
// random push/pop traffic, and checks each response against the table or a stack model.
// Depends on kss_pkg, kss_if and the unit itself.
module testbench;
	import kss_pkg::*;

	localparam int NumStacks   = 4;
	localparam int Capacity    = 16;
	localparam int SlotWidth   = $clog2(Capacity + 1);
	localparam int RandomItems = 1325;
	localparam int DrainCycles = 20;

	typedef logic [SlotWidth-1:0] slot_t;

	typedef struct packed {
		command_t                     command;
		logic [StackIdWidth-1:0]      stack_id;
		logic signed [ValueWidth-1:0] value;
		logic                         typed;
		logic signed [ValueWidth-1:0] data_out;
		status_t                      status;
	} table_row_t;

	// Rows with typed set carry their own expected response.
	localparam table_row_t DirectedRows [25] = '{
		'{CMD_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
		'{CMD_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd3, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_POP,  2'd3, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_OK},
		'{CMD_POP,  2'd3, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
		'{CMD_POP,  2'd0, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK},
		// fill every slot, spread over all stacks
		'{CMD_PUSH, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd2, 32'h5555_5555, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd3, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd0, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd1, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd2, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd3, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd0, 32'h0F0F_0F0F, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd1, 32'hF0F0_F0F0, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd2, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd3, 32'h8765_4321, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd0, 32'h3C3C_3C3C, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd1, 32'hC3C3_C3C3, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd2, 32'h00FF_00FF, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd3, 32'hFF00_FF00, 1'b1, 32'h0000_0000, ST_OK},
		'{CMD_PUSH, 2'd1, 32'h2468_ACE0, 1'b1, 32'h0000_0000, ST_FULL},
		'{CMD_POP,  2'd2, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
		'{CMD_POP,  2'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	kss_if #(.payload_t(req_t)) req_ch ();
	kss_if #(.payload_t(rsp_t)) rsp_ch ();

	k_stacks_shared_array_unit #(
		.NUM_STACKS(NumStacks),
		.CAPACITY  (Capacity),
		.DATA_WIDTH(ValueWidth)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #5 clk = ~clk;

	// Stack model: shared data slots, link chain, per-stack tops and free-list head.
	logic signed [ValueWidth-1:0] model_data [Capacity];
	slot_t                        model_link [Capacity];
	slot_t                        model_top  [NumStacks];
	slot_t                        model_free_head;

	rsp_t pending_results [$];
	int   mismatch_count = 0;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;
	int   stall_left = 0;

	function automatic rsp_t predict_stack_result(input req_t r);
		rsp_t  res;
		slot_t slot;
		res.data_out = '0;
		res.status   = ST_OK;
		if (r.command == CMD_PUSH) begin
			if (int'(r.stack_id) >= NumStacks || model_free_head >= Capacity) begin
				res.status = ST_FULL;
			end else begin
				slot                  = model_free_head;
				model_data[slot]      = r.value;
				model_free_head       = model_link[slot];
				model_link[slot]      = model_top[r.stack_id];
				model_top[r.stack_id] = slot;
			end
		end else begin
			if (int'(r.stack_id) >= NumStacks || model_top[r.stack_id] >= Capacity) begin
				res.status = ST_EMPTY;
			end else begin
				slot                  = model_top[r.stack_id];
				res.data_out          = model_data[slot];
				model_top[r.stack_id] = model_link[slot];
				model_link[slot]      = model_free_head;
				model_free_head       = slot;
			end
		end
		return res;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	task automatic send_request(input req_t item, input rsp_t expected);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(expected);
	endtask

	// Hold the sender until every outstanding response is back.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected response: expected none, actual data_out %0d status %0d",
				$time, got.data_out, got.status);
			mismatch_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.data_out !== want.data_out) begin
			$display("%0t: data_out expected %0d actual %0d", $time, want.data_out, got.data_out);
			mismatch_count++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			mismatch_count++;
		end
	endtask

	// Response side: check each transaction, then stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_result(rsp_ch.payload);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!rx_calm && $urandom_range(99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		req_t item;
		rsp_t predicted;
		rsp_t want;
		int   sent;
		int   phase_len;
		int   push_pct;
		int   focus_stack;
		bit   focused;
		int   pick;

		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;
		for (int i = 0; i < Capacity; i++) begin
			model_data[i] = '0;
			model_link[i] = slot_t'(i + 1);
		end
		for (int i = 0; i < NumStacks; i++)
			model_top[i] = slot_t'(Capacity);
		model_free_head = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DirectedRows); i++) begin
			item.command  = DirectedRows[i].command;
			item.stack_id = DirectedRows[i].stack_id;
			item.value    = DirectedRows[i].value;
			predicted     = predict_stack_result(item);
			if (DirectedRows[i].typed) begin
				want.data_out = DirectedRows[i].data_out;
				want.status   = DirectedRows[i].status;
			end else begin
				want = predicted;
			end
			send_request(item, want);
		end
		wait_for_results();

		sent = 0;
		while (sent < RandomItems) begin
			// Each phase leans toward filling, draining or churning the store.
			phase_len   = $urandom_range(80, 20);
			pick        = $urandom_range(2);
			push_pct    = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
			focused     = ($urandom_range(9) < 3);
			focus_stack = $urandom_range(NumStacks - 1);
			tx_calm     = ($urandom_range(3) == 0);
			rx_calm     = ($urandom_range(3) == 0);
			for (int n = 0; n < phase_len && sent < RandomItems; n++) begin
				item.command = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
				if (focused && $urandom_range(3) != 0)
					item.stack_id = focus_stack[StackIdWidth-1:0];
				else
					item.stack_id = StackIdWidth'($urandom_range(NumStacks - 1));
				pick = $urandom_range(19);
				case (pick)
					0: item.value = 32'h7FFF_FFFF;
					1: item.value = 32'h8000_0000;
					2: item.value = 32'h0000_0000;
					3: item.value = 32'hFFFF_FFFF;
					default: item.value = $urandom;
				endcase
				predicted = predict_stack_result(item);
				send_request(item, predicted);
				sent++;
			end
			if ($urandom_range(99) < 15)
				wait_for_results();
		end

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
